// ===== rtl/wbts_pkg.sv =====
package wbts_pkg;

   // Default sizes of the texture store and the number formats
   localparam int MAX_SIDE_DEF       = 64;
   localparam int TEXEL_BITS_DEF     = 16;
   localparam int COORD_INT_BITS_DEF = 8;

   // Fixed field widths of the stream and register ports
   localparam int IDX_W          = 12;
   localparam int VALUE_W        = 16;
   localparam int COORD_W        = 16;
   localparam int SAMPLE_W       = 16;
   localparam int REQ_TDATA_W    = 64;
   localparam int CFG_W          = 7;
   localparam int CSR_ADDR_W     = 2;
   localparam int CFG_RESET_SIDE = 64;

   // Depth of the result queue; also the number of samples allowed in flight
   localparam int RSP_DEPTH = 2;

   typedef enum logic {
      REQ_WRITE  = 1'b0,
      REQ_SAMPLE = 1'b1
   } req_kind_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_TEX_WIDTH  = 2'd0,
      CSR_TEX_HEIGHT = 2'd1
   } csr_reg_type;

endpackage

// ===== rtl/wbts_front.sv =====
module wbts_front #(
   parameter int MAX_SIDE       = wbts_pkg::MAX_SIDE_DEF,
   parameter int COORD_INT_BITS = wbts_pkg::COORD_INT_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  wbts_pkg::req_kind_type                in_kind,
   input  logic [wbts_pkg::IDX_W-1:0]            in_index,
   input  logic [wbts_pkg::VALUE_W-1:0]          in_value,
   input  logic [wbts_pkg::COORD_W-1:0]          in_cx,
   input  logic [wbts_pkg::COORD_W-1:0]          in_cy,
   input  logic [$clog2(MAX_SIDE+1)-1:0]         tex_width,
   input  logic [$clog2(MAX_SIDE+1)-1:0]         tex_height,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output wbts_pkg::req_kind_type                out_kind,
   output logic [wbts_pkg::IDX_W-1:0]            out_index,
   output logic [wbts_pkg::VALUE_W-1:0]          out_value,
   output logic [$clog2(MAX_SIDE+1)-1:0]         out_x1,
   output logic [$clog2(MAX_SIDE+1)-1:0]         out_y1,
   output logic [((wbts_pkg::COORD_W-COORD_INT_BITS) > 0 ?
                  (wbts_pkg::COORD_W-COORD_INT_BITS) : 1)-1:0] out_fx,
   output logic [((wbts_pkg::COORD_W-COORD_INT_BITS) > 0 ?
                  (wbts_pkg::COORD_W-COORD_INT_BITS) : 1)-1:0] out_fy
);
   import wbts_pkg::*;

   localparam int FRAC_BITS = COORD_W - COORD_INT_BITS;
   localparam int FRAC_W    = FRAC_BITS > 0 ? FRAC_BITS : 1;
   localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
   // Remainder bits resolved per cycle, and cycles per coordinate
   localparam int STEPS     = (COORD_INT_BITS + 3) / 4;
   localparam int MOD_CYC   = (COORD_INT_BITS + STEPS - 1) / STEPS;
   localparam int DIV_W     = MOD_CYC * STEPS;
   localparam int CNT_W     = MOD_CYC > 1 ? $clog2(MOD_CYC) : 1;
   localparam logic [COORD_W-1:0] FMASK = COORD_W'((1 << FRAC_BITS) - 1);

   logic                valid_ff, valid_in;
   req_kind_type        kind_ff;
   logic [IDX_W-1:0]    index_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [FRAC_W-1:0]   fx_ff, fy_ff;
   logic [DIV_W-1:0]    divx_ff, divx_in, divy_ff, divy_in;
   logic [SIDE_W-1:0]   remx_ff, remx_in, remy_ff, remy_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   logic [DIV_W-1:0]    divx_nx, divy_nx;
   logic [SIDE_W-1:0]   remx_nx, remy_nx;
   logic                last, move, accept, step;

   // Restoring remainder, STEPS dividend bits per cycle
   always_comb begin
      logic [SIDE_W:0] tx, ty;
      divx_nx = divx_ff;
      divy_nx = divy_ff;
      remx_nx = remx_ff;
      remy_nx = remy_ff;
      for (int s = 0; s < STEPS; s++) begin
         tx = {remx_nx, divx_nx[DIV_W-1]};
         ty = {remy_nx, divy_nx[DIV_W-1]};
         divx_nx = divx_nx << 1;
         divy_nx = divy_nx << 1;
         if (tx >= {1'b0, tex_width}) begin
            tx = tx - {1'b0, tex_width};
         end
         if (ty >= {1'b0, tex_height}) begin
            ty = ty - {1'b0, tex_height};
         end
         remx_nx = tx[SIDE_W-1:0];
         remy_nx = ty[SIDE_W-1:0];
      end
   end

   assign last      = (cnt_ff == CNT_W'(MOD_CYC - 1));
   assign out_valid = valid_ff && (kind_ff == REQ_WRITE || last);
   assign move      = out_valid && out_ready;
   assign in_ready  = !valid_ff || move;
   assign accept    = in_valid && in_ready;
   // The final step is taken only as the item leaves
   assign step      = valid_ff && kind_ff == REQ_SAMPLE && !last;

   always_comb begin
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      divx_in  = divx_ff;
      divy_in  = divy_ff;
      remx_in  = remx_ff;
      remy_in  = remy_ff;
      if (accept) begin
         valid_in = 1'b1;
         cnt_in   = '0;
         divx_in  = DIV_W'(in_cx >> FRAC_BITS);
         divy_in  = DIV_W'(in_cy >> FRAC_BITS);
         remx_in  = '0;
         remy_in  = '0;
      end else begin
         if (move) begin
            valid_in = 1'b0;
         end
         if (step) begin
            cnt_in  = cnt_ff + CNT_W'(1);
            divx_in = divx_nx;
            divy_in = divy_nx;
            remx_in = remx_nx;
            remy_in = remy_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      divx_ff <= divx_in;
      divy_ff <= divy_in;
      remx_ff <= remx_in;
      remy_ff <= remy_in;
      if (accept) begin
         kind_ff  <= in_kind;
         index_ff <= in_index;
         value_ff <= in_value;
         fx_ff    <= FRAC_W'(in_cx & FMASK);
         fy_ff    <= FRAC_W'(in_cy & FMASK);
      end
   end

   assign out_kind  = kind_ff;
   assign out_index = index_ff;
   assign out_value = value_ff;
   assign out_x1    = remx_nx;
   assign out_y1    = remy_nx;
   assign out_fx    = fx_ff;
   assign out_fy    = fy_ff;

endmodule

// ===== rtl/wrapped_bilinear_texture_sampler_unit.sv =====
// Sample beat: four texel reads on the single-port texture memory, and only while the result
// queue has room; the wrap remainders of the next sample run alongside those reads.
// Write beat: one pass through the front stage and one memory write, no response.
// Reset: synchronous, clears control, sizes return to 64 (capped at MAX_SIDE);
// texture contents are not cleared and stay undefined until written.
module wrapped_bilinear_texture_sampler_unit #(
   parameter int MAX_SIDE       = wbts_pkg::MAX_SIDE_DEF,
   parameter int TEXEL_BITS     = wbts_pkg::TEXEL_BITS_DEF,
   parameter int COORD_INT_BITS = wbts_pkg::COORD_INT_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // texel_index[11:0], texel_value[27:12], coord_x[43:28], coord_y[59:44], zero pad
   input  logic [wbts_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // req_type[0]: 0 writes a texel, 1 samples
   input  logic [0:0]                           req_tuser,
   // response stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // sample_value[15:0]
   output logic [wbts_pkg::SAMPLE_W-1:0]        rsp_tdata,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wbts_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [wbts_pkg::CFG_W-1:0]           csr_wdata
);
   import wbts_pkg::*;

   localparam int FRAC_BITS  = COORD_W - COORD_INT_BITS;
   localparam int FRAC_W     = FRAC_BITS > 0 ? FRAC_BITS : 1;
   localparam int WF_W       = FRAC_BITS + 1;
   localparam int WGT_W      = 2 * WF_W;
   localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
   localparam int RB_W       = 2 * SIDE_W;
   localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int IDX_EXT_W  = ADDR_W > IDX_W ? ADDR_W : IDX_W;
   localparam int VAL_EXT_W  = TEXEL_BITS > VALUE_W ? TEXEL_BITS : VALUE_W;
   localparam int PROD_W     = TEXEL_BITS + WGT_W;
   localparam int SUM_W      = 2 * FRAC_BITS + (TEXEL_BITS > SAMPLE_W ? TEXEL_BITS : SAMPLE_W) + 2;
   localparam int RESET_SIDE = CFG_RESET_SIDE > MAX_SIDE ? MAX_SIDE : CFG_RESET_SIDE;
   localparam int PTR_W      = RSP_DEPTH > 1 ? $clog2(RSP_DEPTH) : 1;
   localparam int CREDIT_W   = $clog2(RSP_DEPTH + 1);
   localparam logic [1:0]      LAST_PHASE = 2'd3;
   localparam logic [WF_W-1:0] ONE        = WF_W'(1 << FRAC_BITS);

   // ---------------------------------------------------------------- registers
   logic [SIDE_W-1:0]  tex_width_ff, tex_height_ff;
   logic [SIDE_W-1:0]  csr_side;

   assign csr_ready = 1'b1;

   // Zero acts as one, anything past MAX_SIDE saturates
   always_comb begin
      if (csr_wdata == '0) begin
         csr_side = SIDE_W'(1);
      end else if (int'(csr_wdata) > MAX_SIDE) begin
         csr_side = SIDE_W'(MAX_SIDE);
      end else begin
         csr_side = SIDE_W'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff  <= SIDE_W'(RESET_SIDE);
         tex_height_ff <= SIDE_W'(RESET_SIDE);
      end else if (csr_valid && csr_ready) begin
         case (csr_addr)
            CSR_TEX_WIDTH:  tex_width_ff  <= csr_side;
            CSR_TEX_HEIGHT: tex_height_ff <= csr_side;
            default: ;
         endcase
      end
   end

   // --------------------------------------------------------------- front stage
   req_kind_type        f_kind;
   logic                f_valid, f_ready;
   logic [IDX_W-1:0]    f_index;
   logic [VALUE_W-1:0]  f_value;
   logic [SIDE_W-1:0]   f_x1, f_y1;
   logic [FRAC_W-1:0]   f_fx, f_fy;

   wbts_front #(
      .MAX_SIDE       (MAX_SIDE),
      .COORD_INT_BITS (COORD_INT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_kind    (req_kind_type'(req_tuser)),
      .in_index   (req_tdata[IDX_W-1:0]),
      .in_value   (req_tdata[IDX_W +: VALUE_W]),
      .in_cx      (req_tdata[IDX_W+VALUE_W +: COORD_W]),
      .in_cy      (req_tdata[IDX_W+VALUE_W+COORD_W +: COORD_W]),
      .tex_width  (tex_width_ff),
      .tex_height (tex_height_ff),
      .out_valid  (f_valid),
      .out_ready  (f_ready),
      .out_kind   (f_kind),
      .out_index  (f_index),
      .out_value  (f_value),
      .out_x1     (f_x1),
      .out_y1     (f_y1),
      .out_fx     (f_fx),
      .out_fy     (f_fy)
   );

   // --------------------------------------------------------------- issue stage
   // Owns the memory port: one write, or four reads for a sample
   logic                b_valid_ff, b_valid_in;
   req_kind_type        b_kind_ff;
   logic                b_wr_en_ff;
   logic [ADDR_W-1:0]   b_waddr_ff;
   logic [TEXEL_BITS-1:0] b_wdata_ff;
   logic [SIDE_W-1:0]   b_x1_ff, b_y1_ff;
   logic [FRAC_W-1:0]   b_fx_ff, b_fy_ff;
   logic [1:0]          b_phase_ff, b_phase_in;
   logic [CREDIT_W-1:0] credit_ff, credit_in;

   logic                b_done, b_load, sample_load, pop;
   logic [IDX_EXT_W-1:0] idx_ext;
   logic [VAL_EXT_W-1:0] val_ext;

   assign b_done      = b_valid_ff && (b_kind_ff == REQ_WRITE || b_phase_ff == LAST_PHASE);
   // A sample starts only if its result already has a place in the queue
   assign f_ready     = (!b_valid_ff || b_done) &&
                        (f_kind == REQ_WRITE || credit_ff < CREDIT_W'(RSP_DEPTH));
   assign b_load      = f_valid && f_ready;
   assign sample_load = b_load && f_kind == REQ_SAMPLE;
   assign idx_ext     = IDX_EXT_W'(f_index);
   assign val_ext     = VAL_EXT_W'(f_value);

   always_comb begin
      b_valid_in = b_valid_ff;
      b_phase_in = b_phase_ff;
      if (b_load) begin
         b_valid_in = 1'b1;
         b_phase_in = '0;
      end else begin
         if (b_done) begin
            b_valid_in = 1'b0;
         end
         if (b_valid_ff && b_kind_ff == REQ_SAMPLE) begin
            b_phase_in = b_phase_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         b_phase_ff <= '0;
      end else begin
         b_valid_ff <= b_valid_in;
         b_phase_ff <= b_phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_load) begin
         b_kind_ff  <= f_kind;
         // drop writes beyond the store
         b_wr_en_ff <= int'(f_index) < DEPTH;
         b_waddr_ff <= idx_ext[ADDR_W-1:0];
         b_wdata_ff <= val_ext[TEXEL_BITS-1:0];
         b_x1_ff    <= f_x1;
         b_y1_ff    <= f_y1;
         b_fx_ff    <= f_fx;
         b_fy_ff    <= f_fy;
      end
   end

   // Phase order: (x1,y1), (x2,y1), (x1,y2), (x2,y2); x2 and y2 are the wrapped neighbors
   logic [SIDE_W-1:0]   x2, y2, col, row;
   logic [RB_W-1:0]     row_base;
   logic [RB_W:0]       rd_addr_full;
   logic [WF_W-1:0]     wx, wy;
   logic [WGT_W-1:0]    wgt;
   logic                mem_we, mem_re;
   logic [ADDR_W-1:0]   mem_addr;

   assign x2 = (b_x1_ff == '0) ? tex_width_ff - SIDE_W'(1)  : b_x1_ff - SIDE_W'(1);
   assign y2 = (b_y1_ff == '0) ? tex_height_ff - SIDE_W'(1) : b_y1_ff - SIDE_W'(1);
   assign col = b_phase_ff[0] ? x2 : b_x1_ff;
   assign row = b_phase_ff[1] ? y2 : b_y1_ff;
   assign row_base     = RB_W'(row) * RB_W'(tex_width_ff);
   assign rd_addr_full = (RB_W+1)'(row_base) + (RB_W+1)'(col);

   // Fraction weight on the current texel, one minus fraction on the neighbor
   assign wx  = b_phase_ff[0] ? ONE - WF_W'(b_fx_ff) : WF_W'(b_fx_ff);
   assign wy  = b_phase_ff[1] ? ONE - WF_W'(b_fy_ff) : WF_W'(b_fy_ff);
   assign wgt = WGT_W'(wx) * WGT_W'(wy);

   assign mem_we   = b_valid_ff && b_kind_ff == REQ_WRITE && b_wr_en_ff;
   assign mem_re   = b_valid_ff && b_kind_ff == REQ_SAMPLE;
   assign mem_addr = (b_kind_ff == REQ_WRITE) ? b_waddr_ff : rd_addr_full[ADDR_W-1:0];

   // ------------------------------------------------------------ texture memory
   logic [TEXEL_BITS-1:0] tex_mem_ff [DEPTH];
   logic [TEXEL_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tex_mem_ff[mem_addr] <= b_wdata_ff;
      end
      rdata_ff <= tex_mem_ff[mem_addr];
   end

   // ------------------------------------------------------------ blend pipeline
   logic                rd_valid_ff, rd_last_ff, p_valid_ff, p_last_ff;
   logic [WGT_W-1:0]    wgt_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [SUM_W-1:0]    acc_ff, acc_in, sum;
   logic                push;

   always_ff @(posedge clock) begin
      wgt_ff     <= wgt;
      rd_last_ff <= b_phase_ff == LAST_PHASE;
      prod_ff    <= PROD_W'(rdata_ff) * PROD_W'(wgt_ff);
      p_last_ff  <= rd_last_ff;
   end

   // Sum the four products exactly, truncate by 2F bits on the last one
   assign sum  = acc_ff + SUM_W'(prod_ff);
   assign push = p_valid_ff && p_last_ff;

   always_comb begin
      acc_in = acc_ff;
      if (p_valid_ff) begin
         acc_in = p_last_ff ? '0 : sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         p_valid_ff  <= 1'b0;
         acc_ff      <= '0;
      end else begin
         rd_valid_ff <= mem_re;
         p_valid_ff  <= rd_valid_ff;
         acc_ff      <= acc_in;
      end
   end

   // ------------------------------------------------------------ response queue
   logic [SAMPLE_W-1:0] rsp_q_ff [RSP_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CREDIT_W-1:0] count_ff, count_in;

   assign rsp_tvalid = count_ff != '0;
   assign rsp_tdata  = rsp_q_ff[rd_ptr_ff];
   assign pop        = rsp_tvalid && rsp_tready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      credit_in = credit_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         count_in  = count_in + CREDIT_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         count_in  = count_in - CREDIT_W'(1);
         credit_in = credit_in - CREDIT_W'(1);
      end
      // hold a credit from sample issue until its beat leaves
      if (sample_load) begin
         credit_in = credit_in + CREDIT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         credit_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         credit_ff <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_q_ff[wr_ptr_ff] <= sum[2*FRAC_BITS +: SAMPLE_W];
      end
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import wbts_pkg::*;

   localparam int CLK_HALF     = 4;
   localparam int RESET_CYCLES = 12;
   localparam int STORE_DEPTH  = MAX_SIDE_DEF * MAX_SIDE_DEF;
   localparam int FRAC_W       = COORD_W - COORD_INT_BITS_DEF;
   // Every resized texture below spans at most this many texels from index 0
   localparam int FILL_TEXELS  = 64;
   // Margin after the last owed sample; lets trailing texel writes settle
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_REPORTS  = 10;

   // Register indexes past the end of the register list; writes there do nothing
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_HI = 2'd3;

   // Shadow of the texture store and the size registers, plus the queue of
   // blended values still owed by the block.
   class texel_sampler_scoreboard;
      logic [VALUE_W-1:0]  texels [STORE_DEPTH];
      logic [CFG_W-1:0]    width_reg  = CFG_W'(CFG_RESET_SIDE);
      logic [CFG_W-1:0]    height_reg = CFG_W'(CFG_RESET_SIDE);
      logic [SAMPLE_W-1:0] owed_samples [$];
      int                  failures = 0;

      function void note_config(logic [CSR_ADDR_W-1:0] addr, logic [CFG_W-1:0] value);
         case (addr)
            CSR_TEX_WIDTH:  width_reg  = value;
            CSR_TEX_HEIGHT: height_reg = value;
            default: ;
         endcase
      endfunction

      // Zero acts as one, anything past the store side saturates
      function int unsigned clamp_side(logic [CFG_W-1:0] r);
         if (r == 0)
            return 1;
         if (r > MAX_SIDE_DEF)
            return MAX_SIDE_DEF;
         return r;
      endfunction

      // Texels covered by the current width and height
      function int unsigned active_texels();
         return clamp_side(width_reg) * clamp_side(height_reg);
      endfunction

      function logic [SAMPLE_W-1:0] blend_at(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
         int unsigned     w, h, fx, fy, one, x_cur, y_cur, x_left, y_up;
         longint unsigned acc;
         w      = clamp_side(width_reg);
         h      = clamp_side(height_reg);
         one    = 1 << FRAC_W;
         fx     = cx[FRAC_W-1:0];
         fy     = cy[FRAC_W-1:0];
         x_cur  = (cx >> FRAC_W) % w;
         y_cur  = (cy >> FRAC_W) % h;
         x_left = (x_cur + w - 1) % w;
         y_up   = (y_cur + h - 1) % h;
         // Fraction weights on the current texel, the rest on the wrapped neighbors
         acc  = 64'(fx * fy) * texels[y_cur * w + x_cur];
         acc += 64'((one - fx) * fy) * texels[y_cur * w + x_left];
         acc += 64'(fx * (one - fy)) * texels[y_up * w + x_cur];
         acc += 64'((one - fx) * (one - fy)) * texels[y_up * w + x_left];
         return SAMPLE_W'(acc >> (2 * FRAC_W));
      endfunction

      function void note_request(req_kind_type kind, logic [IDX_W-1:0] idx,
                                 logic [VALUE_W-1:0] value,
                                 logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
         if (kind == REQ_WRITE)
            texels[idx] = value;
         else
            owed_samples.push_back(blend_at(cx, cy));
      endfunction

      function void check_sample(logic [SAMPLE_W-1:0] got);
         logic [SAMPLE_W-1:0] want;
         if (owed_samples.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("sample beat with nothing owed: sample_value %h", got);
            return;
         end
         want = owed_samples.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("sample_value mismatch: expected %h, got %h", want, got);
         end
      endfunction
   endclass

   texel_sampler_scoreboard sb = new;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   // texel_index, texel_value, coord_x, coord_y from bit 0 up, zero pad on top
   logic [REQ_TDATA_W-1:0]     req_tdata  = '0;
   // req_type
   logic [0:0]                 req_tuser  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   // sample_value
   logic [SAMPLE_W-1:0]        rsp_tdata;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [CSR_ADDR_W-1:0]      csr_addr   = '0;
   logic [CFG_W-1:0]           csr_wdata  = '0;

   // Idle chances in percent for the request side and the response side
   int send_idle = 0;
   int recv_idle = 0;
   int cycles    = 0;

   wrapped_bilinear_texture_sampler_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #CLK_HALF clock = ~clock;

   // Check the beat seen at this edge, then pick tready for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_sample(rsp_tdata);
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
   end

   // Watchdog: stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d samples still owed",
                  cycles, sb.owed_samples.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Random coordinate; now and then pin the fraction to zero or all ones
   function automatic logic [COORD_W-1:0] rand_coord();
      logic [COORD_W-1:0] c;
      c = COORD_W'($urandom_range(0, 65535));
      case ($urandom_range(0, 7))
         0: c[FRAC_W-1:0] = '0;
         1: c[FRAC_W-1:0] = '1;
         default: ;
      endcase
      return c;
   endfunction

   // Two first and two last rows or columns of the full-size texture
   function automatic int edge_line(int k);
      return (k < 2) ? k : MAX_SIDE_DEF - 4 + k;
   endfunction

   // Present one request beat, hold it until accepted, then log it.
   // Always entered right after a rising edge; valid is left high so that
   // back-to-back beats need only one assignment per edge.
   task automatic send_beat(req_kind_type kind, logic [IDX_W-1:0] idx,
                            logic [VALUE_W-1:0] value,
                            logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_TDATA_W'({cy, cx, value, idx});
      do
         @(posedge clock);
      while (!req_tready);
      sb.note_request(kind, idx, value, cx, cy);
   endtask

   // Unused fields of each beat carry random bits
   task automatic write_texel(logic [IDX_W-1:0] idx, logic [VALUE_W-1:0] value);
      send_beat(REQ_WRITE, idx, value, rand_coord(), rand_coord());
   endtask

   task automatic sample_at(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
      send_beat(REQ_SAMPLE, IDX_W'($urandom_range(0, STORE_DEPTH - 1)),
                VALUE_W'($urandom_range(0, 65535)), cx, cy);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      sb.note_config(addr, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait for every owed sample, then let trailing texel writes settle
   task automatic drain();
      while (sb.owed_samples.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly samples, some texel rewrites inside the active texture; the
   // active texture always lies inside the prefilled texels
   task automatic random_beats(int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) < 3)
            write_texel(IDX_W'($urandom_range(0, sb.active_texels() - 1)),
                        VALUE_W'($urandom_range(0, 65535)));
         else
            sample_at(rand_coord(), rand_coord());
      end
      req_tvalid <= 1'b0;
   endtask

   // Resize the texture while idle, then run random traffic at the given idling
   task automatic run_segment(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                              int sidle, int ridle, int count);
      drain();
      write_reg(CSR_TEX_WIDTH, w);
      write_reg(CSR_TEX_HEIGHT, h);
      send_idle = sidle;
      recv_idle = ridle;
      random_beats(count);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the texels used by the small sizes, then the corner blocks that the
      // directed samples at full size reach, so no sample touches an unwritten texel
      for (int i = 0; i < FILL_TEXELS; i++)
         write_texel(IDX_W'(i), VALUE_W'($urandom_range(0, 65535)));
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            write_texel(IDX_W'(edge_line(r) * MAX_SIDE_DEF + edge_line(c)),
                        VALUE_W'($urandom_range(0, 65535)));

      // Directed beats at the reset size of 64 by 64
      send_idle = 20;
      recv_idle = 83;
      write_texel(IDX_W'(STORE_DEPTH - 1), 16'hFFFF);
      write_texel(12'd0, 16'h0000);
      // Zero fraction: all weight on the wrapped upper-left neighbor
      sample_at(16'h0000, 16'h0000);
      // Corner texels all full scale: blend must not exceed range
      write_texel(12'd63, 16'hFFFF);
      write_texel(12'd4032, 16'hFFFF);
      write_texel(12'd0, 16'hFFFF);
      sample_at(16'h0080, 16'h0080);
      sample_at(16'h00FF, 16'h00FF);
      sample_at(16'hFFFF, 16'hFFFF);
      write_texel(12'd0, 16'h0000);
      write_texel(12'd63, 16'h0000);
      write_texel(12'd4032, 16'h0000);
      write_texel(IDX_W'(STORE_DEPTH - 1), 16'h0000);
      sample_at(16'h0080, 16'h0080);
      // Integer part past the side wraps back to zero
      write_texel(12'd2048, 16'h8000);
      sample_at(16'h4000, 16'h4000);
      sample_at(16'h0100, 16'h0100);
      sample_at(16'hFF00, 16'h00FF);
      sample_at(16'h00FF, 16'hFF00);
      write_texel(12'd1, 16'hAAAA);
      write_texel(12'd64, 16'h5555);
      sample_at(16'h8000, 16'h7FFF);
      sample_at(16'h7FFF, 16'h8000);
      sample_at(16'h0180, 16'h0180);
      req_tvalid <= 1'b0;

      // Sender idles lightly, receiver stalls hard
      run_segment(7'd1, 7'd1, 20, 83, 50);
      // Writes to indexes past the register list must change nothing
      drain();
      write_reg(CSR_SPARE_LO, 7'h7F);
      write_reg(CSR_SPARE_HI, 7'h00);
      // Zero width acts as one, oversize height saturates
      run_segment(7'd0, 7'd127, 20, 83, 55);

      // Now the other way round
      run_segment(7'd127, 7'd0, 83, 20, 55);
      run_segment(7'd5, 7'd12, 83, 20, 55);

      // No idling on either side
      run_segment(7'd8, 7'd8, 0, 0, 60);
      run_segment(CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(1, 8)),
                  0, 0, 60);

      drain();
      if (sb.failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== wrapped_bilinear_texture_sampler_unit.f =====
rtl/wbts_pkg.sv
rtl/wbts_front.sv
rtl/wrapped_bilinear_texture_sampler_unit.sv
tb/testbench.sv
